@@ hdl/run_length_block_framebuffer_fill_macros.svh @@
// Assertion macros used by the run-length frame fill datapath.
`ifndef RUN_LENGTH_BLOCK_FRAMEBUFFER_FILL_MACROS_SVH
`define RUN_LENGTH_BLOCK_FRAMEBUFFER_FILL_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define RLFB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RLFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rlfb_pkg.sv @@
// Shared constants, codes and controller/datapath types for the run-length frame fill.
package rlfb_pkg;

  localparam int SCREEN_W   = 256;
  localparam int SCREEN_H   = 192;
  localparam int PIXELS     = SCREEN_W * SCREEN_H;
  localparam int PIX_ADDR_W = $clog2(PIXELS);
  localparam int PIX_W      = 16;
  localparam int EXP_W      = 3;
  localparam int AMT_W      = 16;
  localparam int COORD_W    = 8;
  localparam int SUB_W      = 6;
  localparam int IN_W       = 48;
  localparam int OUT_W      = 40;

  localparam logic [EXP_W-1:0]   MAX_EXP   = 3'd6;
  localparam logic [EXP_W-1:0]   RESET_EXP = 3'd2;
  localparam logic [COORD_W:0]   GRID_W0   = (COORD_W+1)'(SCREEN_W);
  localparam logic [COORD_W-1:0] GRID_H0   = COORD_W'(SCREEN_H);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_PAINT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic clr_start;
    logic clr_step;
    logic run_check;
    logic paint_step;
    logic rd_en;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic run_go;
    logic clr_last;
    logic paint_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hdl/rlfb_ctrl.sv @@
// Sequencing state machine for the run-length frame fill.
module rlfb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  rlfb_pkg::dp_stat_t  stat_i,
  output rlfb_pkg::ctrl_cmd_t cmd_o
);
  import rlfb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (stat_i.cmd)
          CMD_START: state_d = ST_CLEAR;
          CMD_RUN:   state_d = stat_i.run_go ? ST_PAINT : ST_FINISH;
          default:   state_d = ST_FINISH;
        endcase
      end
      ST_CLEAR: begin
        if (stat_i.clr_last) state_d = ST_FINISH;
      end
      ST_PAINT: begin
        if (stat_i.paint_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_INIT: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.load     = req_valid_i;
      end
      ST_DECODE: begin
        unique case (stat_i.cmd)
          CMD_START: cmd_o.clr_start = 1'b1;
          CMD_RUN:   cmd_o.run_check = 1'b1;
          CMD_READ:  cmd_o.rd_en     = 1'b1;
          default:   cmd_o           = '0;
        endcase
      end
      ST_CLEAR:  cmd_o.clr_step   = 1'b1;
      ST_PAINT:  cmd_o.paint_step = 1'b1;
      ST_FINISH: cmd_o.out_load   = stat_i.out_free;
      default:   cmd_o            = '0;
    endcase
  end

endmodule

@@ hdl/rlfb_dpath.sv @@
// Frame store, block cursor, fill counters and result register.
`include "run_length_block_framebuffer_fill_macros.svh"
module rlfb_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rlfb_pkg::ctrl_cmd_t             cmd_i,
  output rlfb_pkg::dp_stat_t              stat_o,
  input  logic [1:0]                      req_cmd_i,
  input  logic [rlfb_pkg::IN_W-1:0]       req_data_i,
  input  logic                            cfg_we_i,
  input  logic [rlfb_pkg::EXP_W-1:0]      cfg_wdata_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic [rlfb_pkg::OUT_W-1:0]      res_data_o
);
  import rlfb_pkg::*;

  // request fields
  cmd_e               cmd_q;
  logic [PIX_W-1:0]   color_q;
  logic [AMT_W-1:0]   amount_q;
  logic [COORD_W-1:0] rx_q, ry_q;

  logic [EXP_W-1:0]   exp_q;
  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic               full_q, full_d;
  logic [SUB_W-1:0]   dx_q, dx_d, dy_q, dy_d;
  logic [AMT_W-1:0]   left_q, left_d;
  logic [PIX_ADDR_W-1:0] clr_addr_q, clr_addr_d;

  logic [PIX_W-1:0]   store_mem [PIXELS];
  logic [PIX_W-1:0]   rd_q;
  logic               res_valid_q;
  logic [OUT_W-1:0]   res_data_q;

  logic [EXP_W-1:0]   e;
  logic [COORD_W:0]   grid_w;
  logic [COORD_W-1:0] grid_h;
  logic [SUB_W-1:0]   sub_mask;
  logic [AMT_W-1:0]   blocks;
  logic               skip, wrap, row_end_pre, grid_done;
  logic [COORD_W-1:0] row_chk, row_inc;
  logic [COORD_W:0]   col_inc;
  logic               dx_end, dy_end, block_end, col_wrap;
  logic [COORD_W-1:0] px, py;
  logic               we;
  logic [PIX_ADDR_W-1:0] waddr;
  logic [PIX_W-1:0]   wdata;
  logic               rd_oob;

  assign e        = (exp_q > MAX_EXP) ? MAX_EXP : exp_q;
  assign grid_w   = GRID_W0 >> e;
  assign grid_h   = GRID_H0 >> e;
  assign sub_mask = SUB_W'(((SUB_W+1)'(1) << e) - (SUB_W+1)'(1));
  assign blocks   = amount_q >> e;

  // run entry: wrap a stale column, then test the row
  assign skip        = full_q || (blocks == '0);
  assign wrap        = {1'b0, col_q} >= grid_w;
  assign row_chk     = wrap ? row_q + COORD_W'(1) : row_q;
  assign row_end_pre = row_chk >= grid_h;

  // block walk
  assign dx_end    = dx_q == sub_mask;
  assign dy_end    = dy_q == sub_mask;
  assign block_end = dx_end && dy_end;
  assign col_inc   = {1'b0, col_q} + (COORD_W+1)'(1);
  assign col_wrap  = col_inc >= grid_w;
  assign row_inc   = row_q + COORD_W'(1);
  assign grid_done = col_wrap && (row_inc >= grid_h);

  assign px = COORD_W'(col_q << e) + COORD_W'(dx_q);
  assign py = COORD_W'(row_q << e) + COORD_W'(dy_q);

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    full_d     = full_q;
    dx_d       = dx_q;
    dy_d       = dy_q;
    left_d     = left_q;
    clr_addr_d = clr_addr_q;
    if (cmd_i.clr_start) begin
      col_d      = '0;
      row_d      = '0;
      full_d     = 1'b0;
      clr_addr_d = '0;
    end
    if (cmd_i.clr_step) begin
      clr_addr_d = stat_o.clr_last ? '0 : clr_addr_q + PIX_ADDR_W'(1);
    end
    if (cmd_i.run_check && !skip) begin
      if (wrap) begin
        col_d = '0;
        row_d = row_chk;
      end
      if (row_end_pre) full_d = 1'b1;
      dx_d   = '0;
      dy_d   = '0;
      left_d = blocks;
    end
    if (cmd_i.paint_step) begin
      dx_d = dx_end ? '0 : dx_q + SUB_W'(1);
      if (dx_end) dy_d = dy_end ? '0 : dy_q + SUB_W'(1);
      if (block_end) begin
        left_d = left_q - AMT_W'(1);
        if (col_wrap) begin
          col_d = '0;
          row_d = row_inc;
          if (row_inc >= grid_h) full_d = 1'b1;
        end else begin
          col_d = col_inc[COORD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q       <= RESET_EXP;
      col_q       <= '0;
      row_q       <= '0;
      full_q      <= 1'b0;
      clr_addr_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) exp_q <= cfg_wdata_i;
      col_q      <= col_d;
      row_q      <= row_d;
      full_q     <= full_d;
      clr_addr_q <= clr_addr_d;
      if (cmd_i.out_load) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    left_q <= left_d;
    if (cmd_i.load) begin
      cmd_q    <= cmd_e'(req_cmd_i);
      color_q  <= req_data_i[15:0];
      amount_q <= req_data_i[31:16];
      rx_q     <= req_data_i[39:32];
      ry_q     <= req_data_i[47:40];
    end
  end

  // frame store: one write port, one registered read port
  assign rd_oob = ry_q >= GRID_H0;
  assign we     = cmd_i.clr_step || cmd_i.paint_step;
  assign waddr  = cmd_i.paint_step ? PIX_ADDR_W'({py, px}) : clr_addr_q;
  assign wdata  = cmd_i.paint_step ? color_q : '0;

  always_ff @(posedge clk_i) begin
    if (we) store_mem[waddr] <= wdata;
    if (cmd_i.rd_en && !rd_oob) rd_q <= store_mem[PIX_ADDR_W'({ry_q, rx_q})];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_data_q <= {7'd0, row_q, col_q, full_q,
                     ((cmd_q == CMD_READ) && !rd_oob) ? rd_q : PIX_W'(0)};
    end
  end

  assign stat_o.cmd        = cmd_q;
  assign stat_o.run_go     = (cmd_q == CMD_RUN) && !skip && !row_end_pre;
  assign stat_o.clr_last   = clr_addr_q == PIX_ADDR_W'(PIXELS - 1);
  assign stat_o.paint_last = block_end && ((left_q == AMT_W'(1)) || grid_done);
  assign stat_o.out_free   = !res_valid_q || res_ready_i;

  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_data_q;

  `RLFB_ASSERT_SAME(a_paint_in_store, cmd_i.paint_step, py < GRID_H0, "paint outside store")
  `RLFB_ASSERT_SAME(a_no_overwrite, cmd_i.out_load, !res_valid_q || res_ready_i,
                    "result overwritten")
  `RLFB_ASSERT_NEXT(a_full_sticks, full_q && !cmd_i.clr_start, full_q,
                    "full flag dropped without start")
  `RLFB_ASSERT_NEXT(a_col_in_grid, cmd_i.paint_step, {1'b0, col_q} < grid_w,
                    "cursor column left grid")

endmodule

@@ hdl/run_length_block_framebuffer_fill.sv @@
// Top level of the run-length block decoder into a 256x192 16-bit frame store.
// After reset the store is swept to zero and no request is taken;
// configuration writes are taken throughout. Every request gives one result.
// A start-frame request re-clears the store. A run request paints
// (run_amount >> e) blocks of 4^e pixels (e = min(divider_exp, 6)), fewer
// if the grid fills, through the single store write port at one pixel per
// cycle. The next request is accepted while the previous result still
// waits on the output side.
// divider_exp may only be written while the block is idle.
module run_length_block_framebuffer_fill (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [rlfb_pkg::IN_W-1:0]    s_axis_tdata,  // run_color, run_amount, read_x, read_y
  input  logic [1:0]                   s_axis_tuser,  // cmd
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [rlfb_pkg::OUT_W-1:0]   m_axis_tdata,  // pixel_value, grid_full, cursor_col,
                                                       // cursor_row, zero pad
  input  logic                         cfg_we_i,
  input  logic [rlfb_pkg::EXP_W-1:0]   cfg_wdata_i    // divider_exp
);
  import rlfb_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  rlfb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .stat_i      (dp_stat),
    .cmd_o       (ctrl_cmd)
  );

  rlfb_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .req_cmd_i   (s_axis_tuser),
    .req_data_i  (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_data_o  (m_axis_tdata)
  );

  assign s_axis_tready = ctrl_cmd.in_ready;

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the run-length block decoder into the 256x192 frame store.
`timescale 1ns / 100ps

module tb_top;
  import rlfb_pkg::*;

  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam int         IDLE_LIMIT = 200000;
  localparam int         PHASE_REQS = 62;

  // tdata layout, lowest bits first: run_color, run_amount, read_x, read_y
  typedef struct packed {
    logic [COORD_W-1:0] rd_y;
    logic [COORD_W-1:0] rd_x;
    logic [AMT_W-1:0]   amount;
    logic [PIX_W-1:0]   color;
  } req_data_t;

  // tdata layout, lowest bits first: pixel_value, grid_full, cursor_col, cursor_row, pad
  typedef struct packed {
    logic [6:0]         pad;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               full;
    logic [PIX_W-1:0]   pixel;
  } frame_rsp_t;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata  = '0;
  logic [1:0]         s_axis_tuser  = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;
  logic               cfg_we_i      = 1'b0;
  logic [EXP_W-1:0]   cfg_wdata_i   = '0;

  // shadow of the block state
  logic [PIX_W-1:0]   shadow_fb [PIXELS];
  int unsigned        cur_col;
  int unsigned        cur_row;
  bit                 grid_done;
  logic [EXP_W-1:0]   div_exp;

  frame_rsp_t         frame_rsp_q [$];
  int                 mismatches    = 0;
  int                 n_start       = 0;
  int                 n_run         = 0;
  int                 n_read        = 0;
  int                 n_other       = 0;
  int                 n_rsp         = 0;
  int                 n_fills       = 0;
  int                 n_div_writes  = 0;
  int                 stuck_cycles  = 0;
  logic [31:0]        stall_pat     = '0;
  int                 stall_cnt     = 0;

  run_length_block_framebuffer_fill i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_frame();
    for (int i = 0; i < PIXELS; i++) shadow_fb[i] = '0;
    cur_col   = 0;
    cur_row   = 0;
    grid_done = 1'b0;
  endfunction

  function automatic int unsigned eff_exp();
    return 32'((div_exp > MAX_EXP) ? MAX_EXP : div_exp);
  endfunction

  // apply one request to the shadow state and return the result it produces
  function automatic frame_rsp_t decode_request(logic [1:0] cmd, req_data_t d);
    frame_rsp_t  rsp;
    int unsigned e;
    int unsigned gw;
    int unsigned gh;
    int unsigned nblk;
    int unsigned px;
    int unsigned py;
    bit          stop;
    rsp  = '0;
    e    = eff_exp();
    gw   = SCREEN_W >> e;
    gh   = SCREEN_H >> e;
    case (cmd)
      CMD_START: clear_frame();
      CMD_RUN: begin
        nblk = 32'(d.amount) >> e;
        stop = grid_done || (nblk == 0);
        if (!stop && cur_col >= gw) begin
          cur_col = 0;
          cur_row++;
        end
        if (!stop && cur_row >= gh) begin
          grid_done = 1'b1;
          n_fills++;
          stop = 1'b1;
        end
        // grid divides the screen exactly, so blocks never cross its edge
        for (int j = 0; j < nblk && !stop; j++) begin
          px = cur_col << e;
          py = cur_row << e;
          for (int y = 0; y < (1 << e); y++) begin
            for (int x = 0; x < (1 << e); x++) begin
              shadow_fb[(py + y) * SCREEN_W + px + x] = d.color;
            end
          end
          cur_col++;
          if (cur_col >= gw) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= gh) begin
              grid_done = 1'b1;
              n_fills++;
              stop = 1'b1;
            end
          end
        end
      end
      CMD_READ: begin
        if (d.rd_y < SCREEN_H) rsp.pixel = shadow_fb[int'(d.rd_y) * SCREEN_W + int'(d.rd_x)];
      end
      default: ;
    endcase
    rsp.full = grid_done;
    rsp.col  = cur_col[COORD_W-1:0];
    rsp.row  = cur_row[COORD_W-1:0];
    return rsp;
  endfunction

  // receiver stall pattern, rotated and renewed when stall_cnt reaches zero
  always @(negedge clk_i) begin
    if (stall_cnt == 0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? '1 : $urandom;
      stall_cnt <= 63;
    end else begin
      stall_pat <= {stall_pat[30:0], stall_pat[31]};
      stall_cnt <= stall_cnt - 1;
    end
    m_axis_tready <= stall_pat[0];
  end

  always @(posedge clk_i) begin : monitor
    frame_rsp_t want;
    frame_rsp_t got;
    if (rst_ni) begin
      if (cfg_we_i) div_exp = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        n_rsp++;
        if (frame_rsp_q.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, got);
          mismatches++;
        end else begin
          want = frame_rsp_q.pop_front();
          if (got.pixel !== want.pixel) begin
            $display("%0t: pixel_value expected %h actual %h", $time, want.pixel, got.pixel);
            mismatches++;
          end
          if (got.full !== want.full) begin
            $display("%0t: grid_full expected %b actual %b", $time, want.full, got.full);
            mismatches++;
          end
          if (got.col !== want.col) begin
            $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, got.col);
            mismatches++;
          end
          if (got.row !== want.row) begin
            $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, got.row);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (s_axis_tuser)
          CMD_START: n_start++;
          CMD_RUN:   n_run++;
          CMD_READ:  n_read++;
          default:   n_other++;
        endcase
        frame_rsp_q.push_back(decode_request(s_axis_tuser, s_axis_tdata));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles == IDLE_LIMIT) begin
        $display("%0t: nothing accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [1:0] cmd, input logic [PIX_W-1:0] color,
                          input logic [AMT_W-1:0] amount, input logic [COORD_W-1:0] x,
                          input logic [COORD_W-1:0] y);
    req_data_t d;
    d = '{rd_y: y, rd_x: x, amount: amount, color: color};
    @(negedge clk_i);
    s_axis_tuser  = cmd;
    s_axis_tdata  = d;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_for(input int n);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = IN_W'({$urandom, $urandom});
    s_axis_tuser  = 2'($urandom);
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic wait_idle();
    idle_for(1);
    while (frame_rsp_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_divider(input logic [EXP_W-1:0] value);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    n_div_writes++;
  endtask

  // empty store at the reset divider, out-of-range rows, unused code
  task automatic test_reset_state();
    send_req(CMD_READ, '0, '0, 8'd0, 8'd0);
    send_req(CMD_READ, '1, '1, 8'd255, 8'd191);
    send_req(CMD_READ, '0, '0, 8'd0, 8'd192);
    send_req(CMD_READ, '0, '0, 8'd255, 8'd255);
    send_req(CMD_NONE, '1, '1, 8'd255, 8'd255);
  endtask

  // zero-block runs, fractional blocks and a few painted blocks at divider 2
  task automatic test_block_paint();
    send_req(CMD_RUN, 16'hFFFF, 16'd0, 8'd0, 8'd0);
    send_req(CMD_RUN, 16'hFFFF, 16'd3, 8'd0, 8'd0);
    send_req(CMD_RUN, 16'hFFFF, 16'd19, 8'd0, 8'd0);
    send_req(CMD_READ, '0, '0, 8'd0, 8'd0);
    send_req(CMD_READ, '0, '0, 8'd15, 8'd3);
    send_req(CMD_READ, '0, '0, 8'd16, 8'd0);
  endtask

  // divider change mid-frame wraps the cursor; fill the grid, then runs are ignored
  task automatic test_divider_change();
    write_divider(3'd0);
    send_req(CMD_RUN, 16'h0F0F, 16'd300, 8'd0, 8'd0);
    send_req(CMD_READ, '0, '0, 8'd47, 8'd1);
    write_divider(3'd6);
    send_req(CMD_RUN, 16'h1234, 16'd64, 8'd0, 8'd0);
    send_req(CMD_READ, '0, '0, 8'd63, 8'd191);
    send_req(CMD_RUN, 16'h8001, 16'hFFFF, 8'd0, 8'd0);
    send_req(CMD_RUN, 16'h0000, 16'hFFFF, 8'd0, 8'd0);
    send_req(CMD_READ, '0, '0, 8'd255, 8'd191);
  endtask

  // divider above six saturates; cursor row beyond the grid marks the frame full
  task automatic test_divider_saturate();
    write_divider(3'd7);
    send_req(CMD_START, '0, '0, 8'd0, 8'd0);
    send_req(CMD_RUN, 16'h5A5A, 16'd63, 8'd0, 8'd0);
    write_divider(3'd0);
    send_req(CMD_RUN, 16'hA5A5, 16'd768, 8'd0, 8'd0);
    write_divider(3'd6);
    send_req(CMD_RUN, 16'h7777, 16'd64, 8'd0, 8'd0);
    send_req(CMD_READ, '0, '0, 8'd200, 8'd2);
    send_req(CMD_READ, '0, '0, 8'd0, 8'd3);
  endtask

  // phases of random traffic, one divider setting per phase
  task automatic test_random_traffic();
    logic [EXP_W-1:0] phase_exp [8];
    logic [1:0]       cmd;
    logic [AMT_W-1:0] amt;
    logic [COORD_W-1:0] ry;
    int               r;
    int               e;
    int               maxb;
    int               nblk;
    int               sent;
    int               burst;
    bit               gaps;
    phase_exp = '{3'd1, 3'd3, 3'd5, 3'd4, 3'd0, 3'd6, 3'd2, 3'd7};
    for (int ph = 0; ph < 8; ph++) begin
      write_divider(phase_exp[ph]);
      if (ph % 2 == 0) begin
        send_req(CMD_START, PIX_W'($urandom), AMT_W'($urandom), COORD_W'($urandom),
                 COORD_W'($urandom));
      end
      gaps = ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_REQS) begin
        burst = $urandom_range(1, 16);
        for (int k = 0; k < burst && sent < PHASE_REQS; k++) begin
          r = $urandom_range(0, 99);
          if (r == 0) cmd = CMD_START;
          else if (r < 6) cmd = CMD_NONE;
          else if (r < 56) cmd = CMD_RUN;
          else cmd = CMD_READ;
          e    = eff_exp();
          maxb = 1300 >> (2 * e);
          if (maxb < 1) maxb = 1;
          nblk = $urandom_range(0, maxb);
          // runs on a full frame are cheap, so they take any amount
          if (grid_done) amt = AMT_W'($urandom);
          else amt = AMT_W'((nblk << e) | ($urandom & ((1 << e) - 1)));
          ry = ($urandom_range(0, 7) == 0) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 191));
          send_req(cmd, PIX_W'($urandom), amt, COORD_W'($urandom), ry);
          sent++;
        end
        if (gaps && $urandom_range(0, 3) != 0) idle_for($urandom_range(1, 12));
      end
    end
  endtask

  initial begin
    clear_frame();
    div_exp = RESET_EXP;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_state();
    test_block_paint();
    test_divider_change();
    test_divider_saturate();
    test_random_traffic();
    wait_idle();
    repeat (20) @(negedge clk_i);
    $display("covered %0d requests: %0d runs, %0d reads, %0d frame starts, %0d unused codes",
             n_start + n_run + n_read + n_other, n_run, n_read, n_start, n_other);
    $display("checked %0d results; grid filled %0d times over %0d divider writes",
             n_rsp, n_fills, n_div_writes);
    if (mismatches == 0 && frame_rsp_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
